FILE: rtl/hdla_pkg.sv
package hdla_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int DVD_W     = 39;
    localparam int PCT_W     = 7;

    localparam logic       FUNC_LOAD   = 1'b0;
    localparam logic       FUNC_WINDOW = 1'b1;

    localparam logic [1:0] MODE_KEEP = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;

    localparam logic [2:0] REG_SLOW       = 3'd0;
    localparam logic [2:0] REG_ERROR      = 3'd1;
    localparam logic [2:0] REG_VOLUME     = 3'd2;
    localparam logic [2:0] REG_LIMITED    = 3'd3;
    localparam logic [2:0] REG_BELOW_UP   = 3'd4;
    localparam logic [2:0] REG_ABOVE_UP   = 3'd5;
    localparam logic [2:0] REG_BELOW_DOWN = 3'd6;
    localparam logic [2:0] REG_ABOVE_DOWN = 3'd7;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

    typedef struct packed {
        logic        func;
        logic [2:0]  entry_index;
        logic [31:0] load_current;
        logic [31:0] load_minimum;
        logic [31:0] load_soft;
        logic [31:0] load_hard;
        logic [31:0] total_requests;
        logic [31:0] limited_requests;
        logic [31:0] error_requests;
        logic [31:0] slow_requests;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  slot;
        logic [31:0] new_limit;
        logic        changed;
        logic [1:0]  mode;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK2,
        ST_CHK3,
        ST_CHK4,
        ST_SEL,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_WB,
        ST_WAIT
    } t_state;

    // percent held to 100 at the top and to lo at the bottom
    function automatic logic [PCT_W-1:0] pct_clamp(input logic [PCT_W-1:0] p,
                                                   input logic [PCT_W-1:0] lo);
        logic [PCT_W-1:0] r;
        r = p;
        if (p > PCT_FULL) r = PCT_FULL;
        else if (p < lo) r = lo;
        return r;
    endfunction

    function automatic logic [31:0] served_calls(input logic [31:0] total,
                                                 input logic [31:0] limited);
        return (total > limited) ? (total - limited) : 32'd0;
    endfunction

endpackage

FILE: rtl/hdla_div.sv
module hdla_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hdla_pkg::DVD_W-1:0] i_dividend,
    input  logic [hdla_pkg::PCT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [hdla_pkg::DVD_W-1:0] o_quotient
);
    import hdla_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quo;
    logic [PCT_W:0]   r_rem;
    logic [PCT_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [PCT_W+1:0] rem_sh;
    logic [PCT_W+1:0] rem_sub;

    // one quotient bit per cycle, restoring
    assign rem_sh  = {r_rem, r_quo[DVD_W-1]};
    assign rem_sub = rem_sh - {2'b00, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (rem_sub[PCT_W+1]) begin
                    r_rem <= rem_sh[PCT_W:0];
                    r_quo <= {r_quo[DVD_W-2:0], 1'b0};
                end else begin
                    r_rem <= rem_sub[PCT_W:0];
                    r_quo <= {r_quo[DVD_W-2:0], 1'b1};
                end
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: rtl/health_driven_limit_adjuster_core.sv
// health driven limit adjuster: a table of up to eight limit entries (current, minimum,
// soft, hard) filled by load transactions and moved by metric window transactions. a load
// transaction writes its slot and gives one result; a load to a
// slot beyond the table is dropped with no result. after a window transaction is accepted,
// the check states judge its health, then the slots are walked one by one: a slot that
// does not move goes from select straight to waiting on its result, a slot that moves
// passes select, multiply, divider start, the shared radix-2 divider (39 quotient bits,
// one per cycle) and write back; that divider serves both the percent scale-down and the
// ceiling scale-up. each slot also waits for its result to be taken.
// each slot result waits in an output register until taken; the input side is not ready
// until the last result of a transaction has been taken.
module health_driven_limit_adjuster_core #(
    parameter int NUM_ENTRIES      = 8,
    parameter int TUNE_UP_PERIOD   = 2,
    parameter int TUNE_DOWN_PERIOD = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  hdla_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output hdla_pkg::t_out_item  o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import hdla_pkg::*;

    localparam int SLOTS = (NUM_ENTRIES < MAX_SLOTS) ? NUM_ENTRIES : MAX_SLOTS;
    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // limit table
    logic [31:0] r_cur  [SLOTS];
    logic [31:0] r_min  [SLOTS];
    logic [31:0] r_soft [SLOTS];
    logic [31:0] r_hard [SLOTS];

    // configuration
    logic [PCT_W-1:0] r_slow_pct, r_err_pct, r_lim_pct;
    logic [PCT_W-1:0] r_bup_pct, r_aup_pct, r_bdn_pct, r_adn_pct;
    logic [31:0]      r_volume;

    // sequencer and datapath
    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [1:0]       r_mode;
    logic [31:0]      r_trig;
    logic [IDX_W-1:0] r_idx;
    logic             r_adj;
    logic             r_last;
    logic             r_slow_hit;
    logic             r_unh;
    logic [DVD_W-1:0] r_pa, r_pb;
    logic [DVD_W-1:0] r_prod;
    logic [PCT_W-1:0] r_p;
    logic [31:0]      r_bound;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             in_acc, out_acc, cfg_wr;
    logic             load_ok;
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_q;
    logic [PCT_W-1:0] div_dvs;
    logic [31:0]      in_normal, it_normal;
    logic             is_last;
    logic [31:0]      cur;

    // slot decision
    logic             sel_act;
    logic [PCT_W-1:0] sel_p;
    logic [31:0]      sel_bound;
    logic [31:0]      wb_val;
    logic [31:0]      trig_base, trig_n;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_acc   = r_out_valid && i_out_ready;
    assign cfg_wr    = psel && penable && pwrite;
    assign load_ok   = ({1'b0, i_in_data.entry_index} < 4'(SLOTS));
    assign in_normal = served_calls(i_in_data.total_requests, i_in_data.limited_requests);
    assign it_normal = served_calls(r_item.total_requests, r_item.limited_requests);
    assign is_last   = (r_idx == IDX_W'(SLOTS - 1));
    assign cur       = r_cur[r_idx];
    assign div_dvs   = (r_mode == MODE_DOWN) ? PCT_FULL : r_p;

    hdla_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // per slot choice of zone, percent and clamp bound
    always_comb begin
        sel_act   = 1'b0;
        sel_p     = PCT_FULL;
        sel_bound = '0;
        unique case (r_mode)
            MODE_DOWN: begin
                if (cur <= r_min[r_idx]) begin
                    sel_act = 1'b0;
                end else if (cur <= r_soft[r_idx]) begin
                    sel_act   = 1'b1;
                    sel_p     = pct_clamp(r_bdn_pct, 7'd0);
                    sel_bound = r_min[r_idx];
                end else if (cur <= r_hard[r_idx] && r_trig >= 32'(TUNE_DOWN_PERIOD)) begin
                    sel_act   = 1'b1;
                    sel_p     = pct_clamp(r_adn_pct, 7'd0);
                    sel_bound = r_soft[r_idx];
                end
            end
            MODE_UP: begin
                if (cur < r_soft[r_idx]) begin
                    sel_act   = 1'b1;
                    sel_p     = pct_clamp(r_bup_pct, 7'd1);
                    sel_bound = r_soft[r_idx];
                end else if (cur < r_hard[r_idx] && r_trig >= 32'(TUNE_UP_PERIOD)) begin
                    sel_act   = 1'b1;
                    sel_p     = pct_clamp(r_aup_pct, 7'd1);
                    sel_bound = r_hard[r_idx];
                end
            end
            default: sel_act = 1'b0;
        endcase
    end

    // clamp the quotient
    always_comb begin
        if (r_mode == MODE_DOWN) begin
            wb_val = (div_q < DVD_W'(r_bound)) ? r_bound : div_q[31:0];
        end else begin
            wb_val = (div_q > DVD_W'(r_bound)) ? r_bound : div_q[31:0];
        end
    end

    // trigger count after mode change and bump
    always_comb begin
        trig_base = r_trig;
        trig_n    = r_trig;
        if (r_unh) begin
            trig_base = (r_mode != MODE_DOWN) ? 32'd0 : r_trig;
            trig_n    = (trig_base == '1) ? trig_base : trig_base + 32'd1;
        end else if (r_item.limited_requests != 32'd0) begin
            trig_base = (r_mode != MODE_UP) ? 32'd0 : r_trig;
            if (r_pa > r_pb) begin
                trig_n = (trig_base == '1) ? trig_base : trig_base + 32'd1;
            end else begin
                trig_n = trig_base;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.func == FUNC_WINDOW) n_state = ST_CHK2;
                    else if (load_ok)                  n_state = ST_WAIT;
                end
            end
            ST_CHK2:  n_state = ST_CHK3;
            ST_CHK3:  n_state = ST_CHK4;
            ST_CHK4:  n_state = ST_SEL;
            ST_SEL:   n_state = sel_act ? ST_MUL : ST_WAIT;
            ST_MUL:   n_state = ST_DIVGO;
            ST_DIVGO: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV:   if (div_done) n_state = ST_WB;
            ST_WB:    n_state = ST_WAIT;
            ST_WAIT:  if (out_acc) n_state = r_last ? ST_IDLE : ST_SEL;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_cur[i]  <= '0;
                r_min[i]  <= '0;
                r_soft[i] <= '0;
                r_hard[i] <= '0;
            end
            r_slow_pct  <= PCT_FULL;
            r_err_pct   <= PCT_FULL;
            r_volume    <= '0;
            r_lim_pct   <= '0;
            r_bup_pct   <= PCT_FULL;
            r_aup_pct   <= PCT_FULL;
            r_bdn_pct   <= PCT_FULL;
            r_adn_pct   <= PCT_FULL;
            r_mode      <= MODE_KEEP;
            r_trig      <= '0;
            r_out_valid <= 1'b0;
            r_adj       <= 1'b0;
            r_last      <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_SLOW:       r_slow_pct <= pwdata[PCT_W-1:0];
                    REG_ERROR:      r_err_pct  <= pwdata[PCT_W-1:0];
                    REG_VOLUME:     r_volume   <= pwdata;
                    REG_LIMITED:    r_lim_pct  <= pwdata[PCT_W-1:0];
                    REG_BELOW_UP:   r_bup_pct  <= pwdata[PCT_W-1:0];
                    REG_ABOVE_UP:   r_aup_pct  <= pwdata[PCT_W-1:0];
                    REG_BELOW_DOWN: r_bdn_pct  <= pwdata[PCT_W-1:0];
                    REG_ABOVE_DOWN: r_adn_pct  <= pwdata[PCT_W-1:0];
                    default:        r_volume   <= r_volume;
                endcase
            end

            if (out_acc) r_out_valid <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_item <= i_in_data;
                        r_idx  <= '0;
                        r_adj  <= 1'b0;
                        // slow check products
                        r_pa <= DVD_W'(in_normal) * DVD_W'(r_slow_pct);
                        r_pb <= DVD_W'(i_in_data.slow_requests) * DVD_W'(PCT_FULL);
                        if (i_in_data.func == FUNC_LOAD && load_ok) begin
                            r_cur[i_in_data.entry_index[IDX_W-1:0]]  <= i_in_data.load_current;
                            r_min[i_in_data.entry_index[IDX_W-1:0]]  <= i_in_data.load_minimum;
                            r_soft[i_in_data.entry_index[IDX_W-1:0]] <= i_in_data.load_soft;
                            r_hard[i_in_data.entry_index[IDX_W-1:0]] <= i_in_data.load_hard;
                            r_out.slot      <= i_in_data.entry_index;
                            r_out.new_limit <= i_in_data.load_current;
                            r_out.changed   <= (r_cur[i_in_data.entry_index[IDX_W-1:0]]
                                                != i_in_data.load_current);
                            r_out.mode      <= r_mode;
                            r_out.last      <= 1'b1;
                            r_out_valid     <= 1'b1;
                            r_last          <= 1'b1;
                        end
                    end
                end
                ST_CHK2: begin
                    r_slow_hit <= (r_pa < r_pb);
                    r_pa <= DVD_W'(it_normal) * DVD_W'(r_err_pct);
                    r_pb <= DVD_W'(r_item.error_requests) * DVD_W'(PCT_FULL);
                end
                ST_CHK3: begin
                    r_unh <= r_slow_hit ||
                             ((r_item.total_requests > r_volume) && (r_pa < r_pb));
                    r_pa <= DVD_W'(r_item.limited_requests) * DVD_W'(PCT_FULL);
                    r_pb <= DVD_W'(r_item.total_requests) * DVD_W'(r_lim_pct);
                end
                ST_CHK4: begin
                    r_trig <= trig_n;
                    if (r_unh)                                 r_mode <= MODE_DOWN;
                    else if (r_item.limited_requests != 32'd0) r_mode <= MODE_UP;
                    else                                       r_mode <= MODE_KEEP;
                end
                ST_SEL: begin
                    r_p     <= sel_p;
                    r_bound <= sel_bound;
                    if (!sel_act) begin
                        r_out.slot      <= 3'(r_idx);
                        r_out.new_limit <= cur;
                        r_out.changed   <= 1'b0;
                        r_out.mode      <= r_mode;
                        r_out.last      <= is_last;
                        r_out_valid     <= 1'b1;
                        r_last          <= is_last;
                    end
                end
                ST_MUL: begin
                    if (r_mode == MODE_DOWN) begin
                        r_prod <= DVD_W'(cur) * DVD_W'(r_p);
                    end else begin
                        r_prod <= DVD_W'(cur) * DVD_W'(PCT_FULL) + DVD_W'(r_p) - DVD_W'(1);
                    end
                end
                ST_WB: begin
                    r_cur[r_idx]    <= wb_val;
                    r_adj           <= 1'b1;
                    r_out.slot      <= 3'(r_idx);
                    r_out.new_limit <= wb_val;
                    r_out.changed   <= (wb_val != cur);
                    r_out.mode      <= r_mode;
                    r_out.last      <= is_last;
                    r_out_valid     <= 1'b1;
                    r_last          <= is_last;
                end
                ST_WAIT: begin
                    if (out_acc) begin
                        if (!r_last) begin
                            r_idx <= r_idx + IDX_W'(1);
                        end else if (r_item.func == FUNC_WINDOW && r_adj) begin
                            // any adjustment restarts the trigger period
                            r_trig <= '0;
                        end
                    end
                end
                default: r_adj <= r_adj;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_SLOW:       prdata = 32'(r_slow_pct);
            REG_ERROR:      prdata = 32'(r_err_pct);
            REG_VOLUME:     prdata = r_volume;
            REG_LIMITED:    prdata = 32'(r_lim_pct);
            REG_BELOW_UP:   prdata = 32'(r_bup_pct);
            REG_ABOVE_UP:   prdata = 32'(r_aup_pct);
            REG_BELOW_DOWN: prdata = 32'(r_bdn_pct);
            REG_ABOVE_DOWN: prdata = 32'(r_adn_pct);
            default:        prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: rtl/hdla_checker.sv
module hdla_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input hdla_pkg::t_out_item o_out_data,
    input logic                pready
);
    import hdla_pkg::*;

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no new transaction while a result is pending
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready with result pending");

    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.mode == MODE_KEEP || o_out_data.mode == MODE_UP ||
                         o_out_data.mode == MODE_DOWN))
        else $error("bad mode code");

    // after a final result is taken the block returns to ready
    a_last_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_data.last |=> o_in_ready)
        else $error("not ready after final result");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind health_driven_limit_adjuster_core hdla_checker u_hdla_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .pready      (pready)
);

FILE: verif/hdla_checker.sv
module hdla_scoreboard #(
    parameter int NUM_ENTRIES      = 8,
    parameter int TUNE_UP_PERIOD   = 2,
    parameter int TUNE_DOWN_PERIOD = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  hdla_pkg::t_in_item   i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  hdla_pkg::t_out_item  i_out_data,
    input  logic                 i_psel,
    input  logic                 i_penable,
    input  logic                 i_pwrite,
    input  logic [4:0]           i_paddr,
    input  logic [31:0]          i_pwdata,
    output int                   o_fail_count,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import hdla_pkg::*;

    localparam int SLOTS = (NUM_ENTRIES < 8) ? NUM_ENTRIES : 8;

    logic [31:0] cur_lim [8];
    logic [31:0] min_lim [8];
    logic [31:0] soft_lim [8];
    logic [31:0] hard_lim [8];
    logic [1:0]  adj_mode;
    logic [31:0] trig_cnt;
    logic [31:0] regs [8];
    t_out_item   limit_results [$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = limit_results.size();

    function automatic logic [63:0] clamp_pct(logic [31:0] p, logic [31:0] lo);
        if (p > 100) return 100;
        if (p < lo) return lo;
        return p;
    endfunction

    function automatic void bump();
        if (trig_cnt != 32'hFFFF_FFFF) trig_cnt++;
    endfunction

    function automatic void enter_mode(logic [1:0] m);
        if (adj_mode != m) begin
            adj_mode = m;
            trig_cnt = 0;
        end
    endfunction

    function automatic logic lower_slots();
        logic        moved;
        logic [63:0] c, v;
        moved = 0;
        for (int i = 0; i < SLOTS; i++) begin
            c = cur_lim[i];
            if (c <= min_lim[i]) continue;
            if (c <= soft_lim[i]) begin
                v = c * clamp_pct(regs[REG_BELOW_DOWN], 0) / 100;
                if (v < min_lim[i]) v = min_lim[i];
            end else if (c <= hard_lim[i] && trig_cnt >= TUNE_DOWN_PERIOD) begin
                v = c * clamp_pct(regs[REG_ABOVE_DOWN], 0) / 100;
                if (v < soft_lim[i]) v = soft_lim[i];
            end else begin
                continue;
            end
            cur_lim[i] = v[31:0];
            moved = 1;
        end
        return moved;
    endfunction

    function automatic logic raise_slots(logic [63:0] total, logic [63:0] limited);
        logic        moved;
        logic [63:0] c, p, v;
        moved = 0;
        if (limited * 100 > total * regs[REG_LIMITED]) bump();
        for (int i = 0; i < SLOTS; i++) begin
            c = cur_lim[i];
            if (c < soft_lim[i]) begin
                p = clamp_pct(regs[REG_BELOW_UP], 1);
                v = (c * 100 + p - 1) / p;
                if (v > soft_lim[i]) v = soft_lim[i];
            end else if (c < hard_lim[i] && trig_cnt >= TUNE_UP_PERIOD) begin
                p = clamp_pct(regs[REG_ABOVE_UP], 1);
                v = (c * 100 + p - 1) / p;
                if (v > hard_lim[i]) v = hard_lim[i];
            end else begin
                continue;
            end
            cur_lim[i] = v[31:0];
            moved = 1;
        end
        return moved;
    endfunction

    // work out the results that one input transaction causes
    function automatic void predict_limits(t_in_item it);
        logic [31:0] prev [8];
        logic [63:0] total, limited, errs, slow, normal;
        t_out_item   r;
        logic        sick;
        if (it.func == FUNC_LOAD) begin
            if (it.entry_index >= SLOTS) return;
            r.changed = cur_lim[it.entry_index] != it.load_current;
            cur_lim[it.entry_index]  = it.load_current;
            min_lim[it.entry_index]  = it.load_minimum;
            soft_lim[it.entry_index] = it.load_soft;
            hard_lim[it.entry_index] = it.load_hard;
            r.slot = it.entry_index;
            r.new_limit = it.load_current;
            r.mode = adj_mode;
            r.last = 1;
            limit_results.push_back(r);
            return;
        end
        total   = it.total_requests;
        limited = it.limited_requests;
        errs    = it.error_requests;
        slow    = it.slow_requests;
        normal  = total > limited ? total - limited : 0;
        for (int i = 0; i < 8; i++) prev[i] = cur_lim[i];
        sick = (normal * regs[REG_SLOW] < slow * 100) ||
               (total > regs[REG_VOLUME] && normal * regs[REG_ERROR] < errs * 100);
        if (sick) begin
            enter_mode(MODE_DOWN);
            bump();
            if (lower_slots()) trig_cnt = 0;
        end else if (limited > 0) begin
            enter_mode(MODE_UP);
            if (raise_slots(total, limited)) trig_cnt = 0;
        end else begin
            adj_mode = MODE_KEEP;
        end
        for (int i = 0; i < SLOTS; i++) begin
            r.slot = i;
            r.new_limit = cur_lim[i];
            r.changed = prev[i] != cur_lim[i];
            r.mode = adj_mode;
            r.last = (i == SLOTS - 1);
            limit_results.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_item e;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                cur_lim[i] = 0;
                min_lim[i] = 0;
                soft_lim[i] = 0;
                hard_lim[i] = 0;
            end
            regs[REG_SLOW] = 100; regs[REG_ERROR] = 100;
            regs[REG_VOLUME] = 0; regs[REG_LIMITED] = 0;
            regs[REG_BELOW_UP] = 100; regs[REG_ABOVE_UP] = 100;
            regs[REG_BELOW_DOWN] = 100; regs[REG_ABOVE_DOWN] = 100;
            adj_mode = MODE_KEEP;
            trig_cnt = 0;
            limit_results.delete();
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite)
                regs[i_paddr[4:2]] = (i_paddr[4:2] == REG_VOLUME) ? i_pwdata
                                                                   : {25'd0, i_pwdata[6:0]};
            if (i_out_valid && i_out_ready) begin
                if (limit_results.size() == 0) begin
                    $error("result with nothing expected: slot %0d", i_out_data.slot);
                    fails++;
                end else begin
                    e = limit_results.pop_front();
                    if (e.slot != i_out_data.slot) begin
                        $error("slot exp %0d got %0d", e.slot, i_out_data.slot); fails++;
                    end
                    if (e.new_limit != i_out_data.new_limit) begin
                        $error("new_limit exp %0d got %0d", e.new_limit,
                               i_out_data.new_limit);
                        fails++;
                    end
                    if (e.changed != i_out_data.changed) begin
                        $error("changed exp %0d got %0d", e.changed, i_out_data.changed);
                        fails++;
                    end
                    if (e.mode != i_out_data.mode) begin
                        $error("mode exp %0d got %0d", e.mode, i_out_data.mode); fails++;
                    end
                    if (e.last != i_out_data.last) begin
                        $error("last exp %0d got %0d", e.last, i_out_data.last); fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_limits(i_in_data);
        end
    end
endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hdla_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk, i_rst_n;
    logic        in_valid, in_ready, out_valid, out_ready;
    t_in_item    in_data;
    t_out_item   out_data;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending;
    int          idle_cycles;
    logic        rx_free;

    health_driven_limit_adjuster_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // checker predicts every result and counts mismatches
    hdla_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver: random stall before each result, sometimes long runs with none
    initial begin
        int stall;
        out_ready = 0;
        rx_free = 0;
        forever begin
            @(negedge i_clk);
            if (rx_free) stall = 0;
            else stall = $urandom_range(0, 10);
            if (stall == 0) begin
                out_ready <= 1;
            end else begin
                out_ready <= 0;
                repeat (stall) @(negedge i_clk);
                out_ready <= 1;
            end
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            if ($urandom_range(0, 40) == 0) rx_free = !rx_free;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // stop offering transactions and wait until every expected result has come
    task automatic pause_input();
        @(negedge i_clk);
        in_valid <= 0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // let every expected result drain, then allow the longest window walk to finish
    task automatic drain();
        pause_input();
        repeat (400) @(negedge i_clk);
    endtask

    // valid stays high right after acceptance so a no-gap transaction follows directly
    task automatic send(t_in_item it, logic no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd32();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 200);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item mk_load(logic [2:0] s, logic [31:0] c, logic [31:0] mn,
                                         logic [31:0] sf, logic [31:0] hd);
        t_in_item it;
        it = '0;
        it.func = FUNC_LOAD;
        it.entry_index = s;
        it.load_current = c; it.load_minimum = mn; it.load_soft = sf; it.load_hard = hd;
        it.total_requests = $urandom; it.limited_requests = $urandom;
        it.error_requests = $urandom; it.slow_requests = $urandom;
        return it;
    endfunction

    function automatic t_in_item mk_win(logic [31:0] t, logic [31:0] l, logic [31:0] e,
                                        logic [31:0] s);
        t_in_item it;
        it = '0;
        it.func = FUNC_WINDOW;
        it.entry_index = 3'($urandom);
        it.load_current = $urandom; it.load_minimum = $urandom;
        it.load_soft = $urandom; it.load_hard = $urandom;
        it.total_requests = t; it.limited_requests = l;
        it.error_requests = e; it.slow_requests = s;
        return it;
    endfunction

    // well-formed entry: minimum <= current, soft, hard ordered
    function automatic t_in_item rnd_entry(logic [2:0] s);
        logic [31:0] a [4];
        logic [31:0] t;
        for (int i = 0; i < 4; i++) a[i] = ($urandom_range(0, 7) == 0) ? rnd32()
                                                                 : $urandom_range(1, 5000);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3 - i; j++)
                if (a[j] > a[j+1]) begin t = a[j]; a[j] = a[j+1]; a[j+1] = t; end
        if ($urandom_range(0, 1)) return mk_load(s, a[1], a[0], a[2], a[3]);
        return mk_load(s, a[2], a[0], a[1], a[3]);
    endfunction

    function automatic t_in_item rnd_window();
        logic [31:0] t;
        t = $urandom_range(0, 3) == 0 ? rnd32() : $urandom_range(0, 1000);
        case ($urandom_range(0, 3))
            0: return mk_win(t, $urandom_range(0, t / 4 + 1), 0, 0);
            1: return mk_win(t, $urandom_range(0, 50), $urandom_range(0, t), 0);
            2: return mk_win(t, 0, 0, $urandom_range(0, t));
            default: return mk_win(rnd32(), rnd32(), rnd32(), rnd32());
        endcase
    endfunction

    initial begin
        i_rst_n = 0;
        in_valid = 0; in_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: zero table stays idle, field extremes, every operation
        send(mk_win(100, 10, 0, 0), 0);
        send(mk_load(3'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
        send(mk_load(3'd7, 0, 0, 0, 0), 0);
        send(mk_load(3'd1, 50, 10, 100, 400), 1);
        send(mk_load(3'd2, 300, 10, 100, 400), 0);
        send(mk_load(3'd3, 100, 10, 100, 400), 0);
        send(mk_load(3'd4, 32'hF000_0000, 1, 32'hF000_0001, 32'hFFFF_FFFF), 0);
        send(mk_load(3'd5, 5, 5, 5, 5), 0);
        send(mk_win(100, 10, 0, 0), 0);          // tune up, trigger advancing
        send(mk_win(100, 10, 0, 0), 0);
        send(mk_win(100, 10, 0, 0), 0);
        send(mk_win(100, 0, 0, 0), 0);           // healthy, nothing limited: keeping
        send(mk_win(100, 0, 0, 200), 0);          // slow calls: tune down
        send(mk_win(100, 0, 0, 200), 0);
        send(mk_win(100, 200, 0, 1), 0);          // limited exceeds total: normal zero
        send(mk_win(32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0), 0);  // errors equal to served calls: error check not met
        send(mk_win(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 0);
        drain();

        // odd settings: out-of-range percents and a zero up percent
        reg_write(REG_SLOW, 0); reg_write(REG_ERROR, 127);
        reg_write(REG_VOLUME, 32'hFFFF_FFFF); reg_write(REG_LIMITED, 127);
        reg_write(REG_BELOW_UP, 0); reg_write(REG_ABOVE_UP, 127);
        reg_write(REG_BELOW_DOWN, 127); reg_write(REG_ABOVE_DOWN, 0);
        send(mk_win(100, 5, 0, 0), 0);
        send(mk_win(100, 5, 0, 1), 0);
        send(mk_win(0, 5, 0, 0), 0);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_SLOW, 20); reg_write(REG_ERROR, 10);
                    reg_write(REG_VOLUME, 50); reg_write(REG_LIMITED, 5);
                    reg_write(REG_BELOW_UP, 80); reg_write(REG_ABOVE_UP, 90);
                    reg_write(REG_BELOW_DOWN, 70); reg_write(REG_ABOVE_DOWN, 85);
                end
                1: begin
                    reg_write(REG_SLOW, 100); reg_write(REG_ERROR, 0);
                    reg_write(REG_VOLUME, 0); reg_write(REG_LIMITED, 0);
                    reg_write(REG_BELOW_UP, 1); reg_write(REG_ABOVE_UP, 1);
                    reg_write(REG_BELOW_DOWN, 0); reg_write(REG_ABOVE_DOWN, 100);
                end
                default: begin
                    for (int r = 0; r < 8; r++)
                        reg_write(r[2:0], (r == REG_VOLUME) ? rnd32()
                                                            : $urandom_range(0, 127));
                end
            endcase
            for (int k = 0; k < 22; k++) begin
                int pick;
                pick = $urandom_range(0, 9);
                if (pick < 3) send(rnd_entry(3'($urandom_range(0, 7))),
                                   $urandom_range(0, 3) == 0);
                else if (pick < 9) send(rnd_window(), $urandom_range(0, 3) == 0);
                else send(mk_load(3'($urandom), rnd32(), rnd32(), rnd32(), rnd32()), 0);
                if (k == 11 && phase == 0) pause_input();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
